// File: design/cbc_pkg.sv
`timescale 1ns / 1ps

package cbc_pkg;

    localparam int COLOR_W      = 8;
    localparam int COORD_W      = 10;
    localparam int RATIO_W      = 4;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd5;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // red, green, blue, column, row packed from bit 0, padded to bytes
    localparam int S_FIELDS_W = 3 * COLOR_W + 2 * COORD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    // centroid_x, centroid_y packed from bit 0, padded to bytes
    localparam int M_FIELDS_W = 2 * COORD_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: design/cbc_divider.sv
`timescale 1ns / 1ps

module cbc_divider
    import cbc_pkg::*;
#(
    parameter int SUM_W   = 31,
    parameter int COUNT_W = 21
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output div_stat_t          stat,
    output logic [COORD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(COORD_W);

    logic [SUM_W-1:0]   rem_reg;
    logic [SUM_W-1:0]   den_reg;
    logic [COORD_W-1:0] quot_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic               fits;
    logic [SUM_W-1:0]   rem_diff;

    // mean of coordinates never exceeds the coordinate range, so only
    // COORD_W quotient bits are developed, msb first
    assign fits     = (rem_reg >= den_reg);
    assign rem_diff = rem_reg - den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(COORD_W - 1);
                rem_reg  <= dividend;
                den_reg  <= SUM_W'({divisor, {(COORD_W-1){1'b0}}});
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= rem_diff;
                end
                quot_reg <= {quot_reg[COORD_W-2:0], fits};
                den_reg  <= den_reg >> 1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> busy_reg)
        else $error("divider did not start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && ($past(step_reg) == '0))
        else $error("divider done before last step");

endmodule

// File: design/color_blob_centroid_core.sv
`timescale 1ns / 1ps
// pixels are taken one per cycle while s_tready is high; a pixel without tlast gives no word out
// a tlast that ends a frame with hits starts two runs of the shared 10-step divider (x, then y),
// the result word shows after the y run, and s_tready stays low till then
// an empty frame skips the divider and goes straight to the output state; a held output word stalls it there
// rst_n (async, active low) clears the sums and count, the output and sets ratio to 5

module color_blob_centroid_core
    import cbc_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [RATIO_W-1:0]   cfg_wr_data,   // dominance_ratio
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pixel_red, pixel_green, pixel_blue, column, row
    input  logic                 s_tlast,   // frame_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // centroid_x, centroid_y
    output logic                 m_tuser    // found
);

    localparam int HIT_CAP_I = MAX_WIDTH * MAX_HEIGHT;
    localparam int COUNT_W   = $clog2(HIT_CAP_I + 1);
    localparam int SUM_W     = COUNT_W + COORD_W;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int COL_LIM_I = (MAX_WIDTH - 1 < COORD_MAX) ? MAX_WIDTH - 1 : COORD_MAX;
    localparam int ROW_LIM_I = (MAX_HEIGHT - 1 < COORD_MAX) ? MAX_HEIGHT - 1 : COORD_MAX;
    localparam logic [COORD_W-1:0] COL_LIM = COORD_W'(COL_LIM_I);
    localparam logic [COORD_W-1:0] ROW_LIM = COORD_W'(ROW_LIM_I);
    localparam logic [COUNT_W-1:0] HIT_CAP = COUNT_W'(HIT_CAP_I);
    localparam int PROD_W = COLOR_W + RATIO_W;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_START_X,
        ST_WAIT_X,
        ST_START_Y,
        ST_WAIT_Y,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [SUM_W-1:0]    col_sum_reg;
    logic [SUM_W-1:0]    row_sum_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                found_reg;
    logic [COORD_W-1:0]  res_x_reg;
    logic [COORD_W-1:0]  res_y_reg;
    logic                m_tvalid_reg;
    logic                m_found_reg;
    logic [COORD_W-1:0]  m_x_reg;
    logic [COORD_W-1:0]  m_y_reg;

    logic [COLOR_W-1:0]  pix_red;
    logic [COLOR_W-1:0]  pix_green;
    logic [COLOR_W-1:0]  pix_blue;
    logic [COORD_W-1:0]  pix_col;
    logic [COORD_W-1:0]  pix_row;
    logic [COORD_W-1:0]  col_clamp;
    logic [COORD_W-1:0]  row_clamp;
    logic [PROD_W-1:0]   prod_red;
    logic [PROD_W-1:0]   prod_green;
    logic                hit;
    logic                take;
    logic                accept;
    logic [SUM_W-1:0]    col_sum_next;
    logic [SUM_W-1:0]    row_sum_next;
    logic [COUNT_W-1:0]  count_next;
    logic                out_free;

    logic                div_start;
    logic [SUM_W-1:0]    div_dividend;
    div_stat_t           div_stat;
    logic [COORD_W-1:0]  div_quot;

    assign pix_red   = s_tdata[COLOR_W-1:0];
    assign pix_green = s_tdata[2*COLOR_W-1:COLOR_W];
    assign pix_blue  = s_tdata[3*COLOR_W-1:2*COLOR_W];
    assign pix_col   = s_tdata[3*COLOR_W+COORD_W-1:3*COLOR_W];
    assign pix_row   = s_tdata[3*COLOR_W+2*COORD_W-1:3*COLOR_W+COORD_W];

    assign col_clamp = (pix_col > COL_LIM) ? COL_LIM : pix_col;
    assign row_clamp = (pix_row > ROW_LIM) ? ROW_LIM : pix_row;

    assign prod_red   = PROD_W'(pix_red) * PROD_W'(ratio_reg);
    assign prod_green = PROD_W'(pix_green) * PROD_W'(ratio_reg);
    assign hit = (PROD_W'(pix_blue) > prod_red) && (PROD_W'(pix_blue) > prod_green);
    // saturating hit count keeps the sums from wrapping
    assign take = hit && (count_reg < HIT_CAP);

    assign s_tready = (state_reg == ST_RUN);
    assign accept   = s_tvalid && s_tready;

    assign col_sum_next = take ? col_sum_reg + SUM_W'(col_clamp) : col_sum_reg;
    assign row_sum_next = take ? row_sum_reg + SUM_W'(row_clamp) : row_sum_reg;
    assign count_next   = take ? count_reg + 1'b1 : count_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    assign div_start    = (state_reg == ST_START_X) || (state_reg == ST_START_Y);
    assign div_dividend = (state_reg == ST_START_X) ? col_sum_reg : row_sum_reg;

    cbc_divider #(
        .SUM_W   (SUM_W),
        .COUNT_W (COUNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
        end
        else if (cfg_wr_en)
        begin
            ratio_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_RUN;
            col_sum_reg  <= '0;
            row_sum_reg  <= '0;
            count_reg    <= '0;
            found_reg    <= 1'b0;
            res_x_reg    <= '0;
            res_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_found_reg  <= 1'b0;
            m_x_reg      <= '0;
            m_y_reg      <= '0;
        end
        else
        begin
            // in the output state a taken word is replaced below
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN:
                begin
                    if (accept)
                    begin
                        col_sum_reg <= col_sum_next;
                        row_sum_reg <= row_sum_next;
                        count_reg   <= count_next;
                        if (s_tlast)
                        begin
                            if (count_next == '0)
                            begin
                                found_reg <= 1'b0;
                                res_x_reg <= '0;
                                res_y_reg <= '0;
                                state_reg <= ST_OUT;
                            end
                            else
                            begin
                                found_reg <= 1'b1;
                                state_reg <= ST_START_X;
                            end
                        end
                    end
                end
                ST_START_X:
                begin
                    state_reg <= ST_WAIT_X;
                end
                ST_WAIT_X:
                begin
                    if (div_stat.done)
                    begin
                        res_x_reg <= div_quot;
                        state_reg <= ST_START_Y;
                    end
                end
                ST_START_Y:
                begin
                    state_reg <= ST_WAIT_Y;
                end
                ST_WAIT_Y:
                begin
                    if (div_stat.done)
                    begin
                        res_y_reg <= div_quot;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_found_reg  <= found_reg;
                        m_x_reg      <= res_x_reg;
                        m_y_reg      <= res_y_reg;
                        col_sum_reg  <= '0;
                        row_sum_reg  <= '0;
                        count_reg    <= '0;
                        state_reg    <= ST_RUN;
                    end
                    else if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = M_TDATA_W'({m_y_reg, m_x_reg});

    a_ready_only_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_RUN))
        else $error("input ready outside run state");

    a_done_while_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_WAIT_X || state_reg == ST_WAIT_Y))
        else $error("divider finished outside a wait state");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_found_reg) |-> (m_x_reg == '0 && m_y_reg == '0))
        else $error("empty frame with nonzero centroid");

endmodule
